>>> design/kmef_pkg.sv
// Package for the Kruskal maze edge filter.
// Holds the payload structs, register indexes, state enums and the engine status struct.
// No dependencies.
`default_nettype none

package kmef_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W = 5;
  localparam int CFG_W   = 6;
  localparam int JOIN_W  = 10;

  localparam logic [JOIN_W-1:0] JOIN_MAX = 10'd1023;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] GRID_SIDE_RESET = 6'd32;

  typedef struct packed {
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               goes_down;
  } kmef_in_t;

  typedef struct packed {
    logic wall_carved;
    logic edge_invalid;
    logic maze_complete;
  } kmef_out_t;

  // Status from the union-find engine to the top level.
  typedef struct packed {
    logic idle;
    logic done;
    logic carved;
  } kmef_uf_status_t;

  typedef enum logic [2:0] {
    UF_CLEAR,
    UF_IDLE,
    UF_FIND_RD,
    UF_FIND_CHK,
    UF_COMP_RD,
    UF_COMP_CHK
  } kmef_uf_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_RESP
  } kmef_top_state_t;

endpackage

`default_nettype wire

>>> design/kmef_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module kmef_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> design/kmef_uf_engine.sv
// Union-find engine: parent table memory, find with path compression, link of two roots.
// Depends on kmef_pkg and kmef_ram.
`default_nettype none

module kmef_uf_engine import kmef_pkg::*; #(
  parameter int CELLS = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [$clog2(CELLS)-1:0] idx_a,
  input  wire logic [$clog2(CELLS)-1:0] idx_b,
  output kmef_uf_status_t               status
);

  localparam int IDX_W = $clog2(CELLS);

  kmef_uf_state_t   state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] idx_b_r, idx_b_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] ra_r, ra_nxt;
  logic             side_r, side_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] wdata;
  logic [IDX_W-1:0] rdata;

  kmef_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CELLS)
  ) u_parent_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cur_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= UF_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    cur_r   <= cur_nxt;
    start_r <= start_nxt;
    idx_b_r <= idx_b_nxt;
    root_r  <= root_nxt;
    ra_r    <= ra_nxt;
    side_r  <= side_nxt;
  end

  // The read address is always cur_r; a check state sees the parent of the node that
  // the preceding read state presented.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    idx_b_nxt     = idx_b_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    side_nxt      = side_r;
    we            = 1'b0;
    waddr         = cur_r;
    wdata         = root_r;
    status.idle   = 1'b0;
    status.done   = 1'b0;
    status.carved = 1'b0;

    case (state_r)
      UF_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(CELLS - 1)) begin
          state_nxt = UF_IDLE;
        end
      end
      UF_IDLE: begin
        status.idle = 1'b1;
        if (start) begin
          cur_nxt   = idx_a;
          start_nxt = idx_a;
          idx_b_nxt = idx_b;
          side_nxt  = 1'b0;
          state_nxt = UF_FIND_RD;
        end
      end
      UF_FIND_RD: begin
        state_nxt = UF_FIND_CHK;
      end
      UF_FIND_CHK: begin
        if (rdata == cur_r) begin
          root_nxt  = cur_r;
          cur_nxt   = start_r;
          state_nxt = UF_COMP_RD;
        end else begin
          cur_nxt   = rdata;
          state_nxt = UF_FIND_RD;
        end
      end
      UF_COMP_RD: begin
        state_nxt = UF_COMP_CHK;
      end
      UF_COMP_CHK: begin
        if (rdata != root_r) begin
          // Point this node straight at the root and move on along the old chain.
          we        = 1'b1;
          waddr     = cur_r;
          wdata     = root_r;
          cur_nxt   = rdata;
          state_nxt = UF_COMP_RD;
        end else if (!side_r) begin
          ra_nxt    = root_r;
          cur_nxt   = idx_b_r;
          start_nxt = idx_b_r;
          side_nxt  = 1'b1;
          state_nxt = UF_FIND_RD;
        end else begin
          // Both roots known: link the first root under the second when they differ.
          status.done   = 1'b1;
          status.carved = (ra_r != root_r);
          we            = (ra_r != root_r);
          waddr         = ra_r;
          wdata         = root_r;
          state_nxt     = UF_IDLE;
        end
      end
      default: begin
        state_nxt = UF_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/kruskal_maze_edge_filter.sv
// Top level of the Kruskal maze edge filter: configuration, bounds check, join count, result register.
// Depends on kmef_pkg and kmef_uf_engine.
//
//   channel   direction  handshake             payload
//   in_*      input      in_valid / in_ready   kmef_in_t  (cell_col, cell_row, goes_down)
//   out_*     output     out_valid / out_ready kmef_out_t (wall_carved, edge_invalid, maze_complete)
//   cfg_*     input      cfg_we                cfg_index selects grid_width or grid_height
//
// An edge outside the grid skips the union-find engine and goes through the response state to
// the output register. For an edge inside the grid, each node on the parent chains of its two
// cells costs a read and a check in the parent table memory, once to find the root and once to
// compress the path. After reset all MAX_SIDE*MAX_SIDE entries of the parent table are cleared,
// one entry a cycle, and no transaction is taken meanwhile. One edge is in work at a time; a
// finished result waits in the output register while the next edge is accepted.
`default_nettype none

module kruskal_maze_edge_filter import kmef_pkg::*; #(
  parameter int MAX_SIDE = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire kmef_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output kmef_out_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W = $clog2(CELLS);

  kmef_top_state_t   state_r, state_nxt;
  logic [CFG_W-1:0]  grid_width_r, grid_width_nxt;
  logic [CFG_W-1:0]  grid_height_r, grid_height_nxt;
  logic [JOIN_W-1:0] joins_r, joins_nxt;
  logic              out_valid_r, out_valid_nxt;
  kmef_out_t         out_data_r, out_data_nxt;
  logic              carved_r, carved_nxt;
  logic              invalid_r, invalid_nxt;

  logic [CFG_W-1:0]  eff_w, eff_h;
  logic [CFG_W-1:0]  col1, row1, col2, row2;
  logic              edge_bad;
  logic [11:0]       cell_total;
  logic              complete;
  logic              in_fire;
  logic              eng_start;
  logic [IDX_W-1:0]  idx_a, idx_b;
  kmef_uf_status_t   eng_status;

  kmef_uf_engine #(
    .CELLS (CELLS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (eng_start),
    .idx_a  (idx_a),
    .idx_b  (idx_b),
    .status (eng_status)
  );

  // A side register above MAX_SIDE is limited to it; that only happens when MAX_SIDE is below 63.
  assign eff_w = (32'(grid_width_r) > MAX_SIDE) ? CFG_W'(MAX_SIDE) : grid_width_r;
  assign eff_h = (32'(grid_height_r) > MAX_SIDE) ? CFG_W'(MAX_SIDE) : grid_height_r;

  assign col1 = {1'b0, in_data.cell_col};
  assign row1 = {1'b0, in_data.cell_row};
  assign col2 = in_data.goes_down ? col1 : col1 + 1'b1;
  assign row2 = in_data.goes_down ? row1 + 1'b1 : row1;

  assign edge_bad = (col1 >= eff_w) || (row1 >= eff_h) || (col2 >= eff_w) || (row2 >= eff_h);

  assign idx_a = IDX_W'(32'(row1) * MAX_SIDE + 32'(col1));
  assign idx_b = IDX_W'(32'(row2) * MAX_SIDE + 32'(col2));

  assign cell_total = 12'(eff_w) * 12'(eff_h);
  assign complete   = (12'(joins_r) + 12'd1) >= cell_total;

  assign in_ready  = (state_r == ST_IDLE) && eng_status.idle;
  assign in_fire   = in_valid && in_ready;
  assign eng_start = in_fire && !edge_bad;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      grid_width_r  <= GRID_SIDE_RESET;
      grid_height_r <= GRID_SIDE_RESET;
      joins_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      joins_r       <= joins_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    carved_r   <= carved_nxt;
    invalid_r  <= invalid_nxt;
  end

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width_nxt  = cfg_wdata;
        REG_GRID_HEIGHT: grid_height_nxt = cfg_wdata;
        default: begin
          grid_width_nxt = grid_width_r;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    joins_nxt     = joins_r;
    carved_nxt    = carved_r;
    invalid_nxt   = invalid_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          carved_nxt  = 1'b0;
          invalid_nxt = edge_bad;
          state_nxt   = edge_bad ? ST_RESP : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (eng_status.done) begin
          carved_nxt = eng_status.carved;
          if (eng_status.carved && (joins_r != JOIN_MAX)) begin
            joins_nxt = joins_r + 1'b1;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        // The completion test sees the join count after this transaction's join.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.wall_carved   = carved_r;
          out_data_nxt.edge_invalid  = invalid_r;
          out_data_nxt.maze_complete = complete;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> verif/kmef_carve_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Kruskal maze edge filter: mirrors the union-find table and grid registers,
// predicts one result per accepted edge and compares it with the result channel.
// Depends on kmef_pkg.
module kmef_carve_checker import kmef_pkg::*; #(
  parameter int SIDE = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  kmef_in_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  kmef_out_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int unsigned      error_count,
  output int unsigned      pending_results
);

  localparam int CELLS       = SIDE * SIDE;
  localparam int REPORT_MAX  = 10;
  localparam int AWAIT_DEPTH = 8;

  int unsigned owner [CELLS];
  int unsigned joins_made;
  int unsigned cols_set;
  int unsigned rows_set;
  int unsigned failures = 0;
  kmef_out_t   awaited [AWAIT_DEPTH];
  int unsigned await_rd;
  int unsigned await_wr;
  int unsigned await_count;

  function automatic int unsigned clip_side(input int unsigned v);
    return (v > SIDE) ? SIDE : v;
  endfunction

  // Walks to the set root, then points every cell on the walk straight at it.
  function automatic int unsigned set_root(input int unsigned first_idx);
    int unsigned head;
    int unsigned walk;
    int unsigned nxt;
    head = first_idx;
    while (owner[head] != head) head = owner[head];
    walk = first_idx;
    while (owner[walk] != head) begin
      nxt = owner[walk];
      owner[walk] = head;
      walk = nxt;
    end
    return head;
  endfunction

  function automatic kmef_out_t carve_wall(input kmef_in_t e);
    int unsigned w;
    int unsigned h;
    int unsigned c1;
    int unsigned r1;
    int unsigned c2;
    int unsigned r2;
    int unsigned ra;
    int unsigned rb;
    kmef_out_t   res;
    w  = clip_side(cols_set);
    h  = clip_side(rows_set);
    c1 = 32'(e.cell_col);
    r1 = 32'(e.cell_row);
    c2 = e.goes_down ? c1 : c1 + 1;
    r2 = e.goes_down ? r1 + 1 : r1;
    res = '0;
    if (c1 >= w || r1 >= h || c2 >= w || r2 >= h) begin
      res.edge_invalid = 1'b1;
    end else begin
      ra = set_root(r1 * SIDE + c1);
      rb = set_root(r2 * SIDE + c2);
      if (ra != rb) begin
        owner[ra] = rb;
        if (joins_made < JOIN_MAX) joins_made++;
        res.wall_carved = 1'b1;
      end
    end
    // A zero-sized grid makes the product zero, so the flag is always set there.
    res.maze_complete = (joins_made + 1 >= w * h);
    return res;
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : watch
    kmef_out_t want;
    kmef_out_t pred;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) owner[i] = i;
      joins_made  = 0;
      cols_set    = 32'(GRID_SIDE_RESET);
      rows_set    = 32'(GRID_SIDE_RESET);
      await_rd    = 0;
      await_wr    = 0;
      await_count = 0;
    end else begin
      // A result cannot belong to an edge taken at the same edge, so results go first.
      if (out_valid && out_ready) begin
        if (await_count == 0) begin
          note_failure($sformatf("result with nothing outstanding: carved=%b invalid=%b complete=%b",
                                 out_data.wall_carved, out_data.edge_invalid,
                                 out_data.maze_complete));
        end else begin
          want        = awaited[await_rd];
          await_rd    = (await_rd + 1) % AWAIT_DEPTH;
          await_count = await_count - 1;
          if (want.wall_carved   != out_data.wall_carved  ||
              want.edge_invalid  != out_data.edge_invalid ||
              want.maze_complete != out_data.maze_complete) begin
            note_failure($sformatf({"result mismatch: expected carved=%b invalid=%b ",
                                    "complete=%b, got carved=%b invalid=%b complete=%b"},
                                   want.wall_carved, want.edge_invalid, want.maze_complete,
                                   out_data.wall_carved, out_data.edge_invalid,
                                   out_data.maze_complete));
          end
        end
      end
      if (in_valid && in_ready) begin
        pred = carve_wall(in_data);
        if (await_count == AWAIT_DEPTH) begin
          note_failure("more transactions outstanding than the block can hold");
        end else begin
          awaited[await_wr] = pred;
          await_wr          = (await_wr + 1) % AWAIT_DEPTH;
          await_count       = await_count + 1;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_GRID_WIDTH) cols_set = 32'(cfg_wdata);
        else rows_set = 32'(cfg_wdata);
      end
    end
    error_count     <= failures;
    pending_results <= await_count;
  end

endmodule

>>> verif/kruskal_maze_edge_filter_test.sv
`timescale 1ns / 100ps
// Top of the maze edge filter testbench: clock, reset, grid setup, edge stimulus and verdict.
// Depends on kmef_pkg, kruskal_maze_edge_filter and kmef_carve_checker.
module kruskal_maze_edge_filter_test;
  import kmef_pkg::*;

  localparam int   SIDE        = 32;
  localparam int   CYCLE_LIMIT = 1_000_000;
  localparam int   HOLD_CYCLES = 400;
  localparam int   NOISE_PCT   = 15;
  localparam int   WALL_MAX    = 2 * SIDE * SIDE;
  localparam int   RAW_W       = $bits(kmef_in_t);
  localparam logic GO_RIGHT    = 1'b0;
  localparam logic GO_DOWN     = 1'b1;

  // Which side idles: receiver mostly, sender mostly, or neither.
  typedef enum logic [1:0] {
    PACE_RX_SLOW,
    PACE_TX_SLOW,
    PACE_FREE
  } pace_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  kmef_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  kmef_out_t        out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_GRID_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int unsigned      error_count;
  int unsigned      pending_results;

  pace_t       pace          = PACE_RX_SLOW;
  int unsigned holds_asked   = 0;
  int unsigned holds_granted = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  // Shuffled walls of the current phase and how far they have been used.
  kmef_in_t    deck [WALL_MAX];
  int unsigned deck_len = 0;
  int unsigned deck_pos = 0;

  kruskal_maze_edge_filter #(.MAX_SIDE(SIDE)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  kmef_carve_checker #(.SIDE(SIDE)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Result side: a requested hold-off takes priority over the random stalls.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_granted) begin
      out_ready     <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      holds_granted <= holds_granted + 1;
    end else begin
      case (pace)
        PACE_RX_SLOW: out_ready <= ($urandom_range(99) >= 77);
        PACE_TX_SLOW: out_ready <= ($urandom_range(99) >= 23);
        default:      out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic kmef_in_t wall(input int unsigned col, input int unsigned row,
                                    input logic dir);
    kmef_in_t e;
    e.cell_col  = COORD_W'(col);
    e.cell_row  = COORD_W'(row);
    e.goes_down = dir;
    return e;
  endfunction

  task automatic send_edge(input kmef_in_t e);
    int unsigned gap;
    case (pace)
      PACE_RX_SLOW: gap = 23;
      PACE_TX_SLOW: gap = 77;
      default:      gap = 0;
    endcase
    if ($urandom_range(99) < gap) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  // Every edge yields a result, so no results outstanding means the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic set_grid(input int unsigned cols, input int unsigned rows);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_wdata <= CFG_W'(rows);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // All inner walls of a cols x rows grid, shuffled like a randomized Kruskal pass.
  task automatic deal_walls(input int unsigned cols, input int unsigned rows);
    kmef_in_t    tmp;
    int unsigned j;
    deck_len = 0;
    deck_pos = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (c + 1 < cols) begin
          deck[deck_len] = wall(c, r, GO_RIGHT);
          deck_len++;
        end
        if (r + 1 < rows) begin
          deck[deck_len] = wall(c, r, GO_DOWN);
          deck_len++;
        end
      end
    end
    for (int i = deck_len - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = deck[i];
      deck[i] = deck[j];
      deck[j] = tmp;
    end
  endtask

  task automatic random_phase(input pace_t mode, input int unsigned cols,
                              input int unsigned rows, input int unsigned count);
    logic [RAW_W-1:0] raw;
    int unsigned      cw;
    int unsigned      rh;
    pace <= mode;
    set_grid(cols, rows);
    cw = (cols > SIDE) ? SIDE : cols;
    rh = (rows > SIDE) ? SIDE : rows;
    deck_len = 0;
    deck_pos = 0;
    repeat (count) begin
      if (deck_pos == deck_len) deal_walls(cw, rh);
      if (deck_pos == deck_len || $urandom_range(99) < NOISE_PCT) begin
        raw = RAW_W'($urandom_range(2 ** RAW_W - 1));
        send_edge(kmef_in_t'(raw));
      end else begin
        send_edge(deck[deck_pos]);
        deck_pos++;
      end
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_grid(SIDE, SIDE);

    // Walls off the right and bottom borders, then small closed loops in the top and bottom corners.
    send_edge(wall(31, 0, GO_RIGHT));
    send_edge(wall(0, 31, GO_DOWN));
    send_edge(wall(31, 31, GO_DOWN));
    send_edge(wall(31, 31, GO_RIGHT));
    send_edge(wall(0, 0, GO_RIGHT));
    send_edge(wall(0, 0, GO_DOWN));
    send_edge(wall(1, 0, GO_DOWN));
    send_edge(wall(0, 1, GO_RIGHT));
    send_edge(wall(30, 31, GO_RIGHT));
    send_edge(wall(31, 30, GO_DOWN));
    send_edge(wall(31, 30, GO_DOWN));
    send_edge(wall(30, 30, GO_RIGHT));
    send_edge(wall(30, 30, GO_DOWN));
    drain();

    // Empty grids in either direction.
    set_grid(0, SIDE);
    send_edge(wall(0, 0, GO_RIGHT));
    drain();
    set_grid(5, 0);
    send_edge(wall(0, 0, GO_DOWN));
    drain();

    // A single column, then register values above the largest side.
    set_grid(1, 2);
    send_edge(wall(0, 0, GO_DOWN));
    send_edge(wall(0, 0, GO_RIGHT));
    drain();
    set_grid(63, 33);
    send_edge(wall(31, 30, GO_RIGHT));
    send_edge(wall(15, 16, GO_DOWN));
    drain();

    random_phase(PACE_RX_SLOW, 6, 6, 150);
    random_phase(PACE_RX_SLOW, 12, 10, 200);
    random_phase(PACE_TX_SLOW, 32, 32, 250);
    random_phase(PACE_TX_SLOW, 1, 32, 60);
    random_phase(PACE_TX_SLOW, 2, 2, 40);
    // The result side stops for a long while so the block backs up into the edge channel.
    holds_asked <= holds_asked + 1;
    random_phase(PACE_FREE, 63, 40, 250);
    random_phase(PACE_FREE, 0, 0, 20);
    random_phase(PACE_FREE, 20, 3, 130);

    repeat (40) @(posedge clk);
    if (error_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
